/* hw/rtl/hsl2rgb_pkg.sv */
// ----------------------------------------------------------------------------
// HSL to RGB converter package
// Fixed-point formats, derived widths and the hue weighting function.
// ----------------------------------------------------------------------------
package hsl2rgb_pkg;

  localparam int FRAC_BITS = 16;

  // Field widths of the pixel words.
  localparam int HUE_W = FRAC_BITS;
  localparam int SL_W  = FRAC_BITS + 1;
  localparam int CH_W  = 8;
  localparam int NUM_CH = 3;

  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;

  // Internal widths.
  localparam int LS_W  = 2 * SL_W;              // l * s
  localparam int Q2_W  = 2 * FRAC_BITS + 3;     // q at scale ONE^2
  localparam int PQ_W  = FRAC_BITS + 3;         // p, q and q - p in Q.F
  localparam int K_W   = FRAC_BITS + 1;         // hue weight 0..ONE
  localparam int PR_W  = PQ_W + K_W;            // (q - p) * k
  localparam int NUM_W = PQ_W + FRAC_BITS + 2;  // p * ONE + (q - p) * k
  localparam int SC_W  = NUM_W + 8;             // num * 255 + half
  localparam int RES_W = SC_W - 2 * FRAC_BITS;

  localparam logic [SL_W-1:0]  ONE   = SL_W'(1) << FRAC_BITS;
  localparam logic [SL_W-1:0]  HALF_ONE = SL_W'(1) << (FRAC_BITS - 1);
  localparam logic [HUE_W-1:0] THIRD = HUE_W'((64'd1 << FRAC_BITS) / 3);
  localparam logic [Q2_W-1:0]  Q_RND = Q2_W'(1) << (FRAC_BITS - 1);
  localparam logic [SC_W-1:0]  C_RND = SC_W'(1) << (2 * FRAC_BITS - 1);
  localparam logic [CH_W-1:0]  CH_MAX = '1;

  // Piecewise weight k of the hue position t, so that the channel value is
  // p + (q - p) * k / ONE.
  function automatic logic [K_W-1:0] hue_weight(input logic [HUE_W-1:0] t);
    logic [HUE_W+2:0] t6;
    logic [HUE_W+1:0] t3;
    logic [HUE_W+2:0] k_fall;
    begin
      t6 = ({3'b000, t} << 2) + ({3'b000, t} << 1);
      t3 = {2'b00, t} + ({2'b00, t} << 1);
      k_fall = ((HUE_W + 3)'(ONE) << 2) - t6;
      if (t6 < (HUE_W + 3)'(ONE)) begin
        hue_weight = t6[K_W-1:0];
      end else if (!t[HUE_W-1]) begin
        hue_weight = ONE;
      end else if (t3 < ((HUE_W + 2)'(ONE) << 1)) begin
        hue_weight = k_fall[K_W-1:0];
      end else begin
        hue_weight = '0;
      end
    end
  endfunction

endpackage

/* hw/rtl/hsl_to_rgb_converter_top.sv */
// ----------------------------------------------------------------------------
// HSL to RGB converter, top level
// Five-stage pipeline turning a fixed-point HSL pixel into 8-bit RGB.
// ----------------------------------------------------------------------------
// One pixel word is taken in every cycle while the output is not stalled, and
// its RGB word passes through the five register stages (saturation product,
// p/q and hue weights, weight products, channel sum, scale and clamp). Each
// stage holds its own valid bit, so a stalled output only holds back the
// stages behind it that are full and bubbles are squeezed out. Hue is an
// unsigned fraction of a turn; saturation and lightness above 1.0 are
// limited to 1.0. Channels are rounded half up and clamped to 0..255.
module hsl_to_rgb_converter_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // hue[15:0], saturation[32:16], lightness[49:33], zeros
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // red[7:0], green[15:8], blue[23:16]
);
  import hsl2rgb_pkg::*;

  logic [5:1] v_r;
  logic [5:1] v_nxt;
  logic [5:1] rdy;

  // Stage 1
  logic [HUE_W-1:0] h1_r, h1_nxt;
  logic [SL_W-1:0]  s1_r, s1_nxt;
  logic [SL_W-1:0]  l1_r, l1_nxt;
  logic [LS_W-1:0]  ls1_r, ls1_nxt;
  logic [HUE_W-1:0] in_hue;
  logic [SL_W-1:0]  in_sat;
  logic [SL_W-1:0]  in_light;

  // Stage 2
  logic [PQ_W-1:0]  p2_r, p2_nxt;
  logic [PQ_W-1:0]  d2_r, d2_nxt;
  logic [K_W-1:0]   k2_r [NUM_CH];
  logic [K_W-1:0]   k2_nxt [NUM_CH];
  logic [Q2_W-1:0]  q2_wide;
  logic [Q2_W-1:0]  q2_rnd;
  logic [PQ_W-1:0]  q_raw;
  logic [PQ_W:0]    p_diff;
  logic [PQ_W-1:0]  p_pos;
  logic [PQ_W-1:0]  q_fin;
  logic [HUE_W-1:0] t_red;
  logic [HUE_W-1:0] t_blue;

  // Stage 3
  logic [PQ_W-1:0]  p3_r, p3_nxt;
  logic [PR_W-1:0]  prod3_r [NUM_CH];
  logic [PR_W-1:0]  prod3_nxt [NUM_CH];

  // Stage 4
  logic [NUM_W-1:0] num4_r [NUM_CH];
  logic [NUM_W-1:0] num4_nxt [NUM_CH];

  // Stage 5
  logic [CH_W-1:0]  rgb5_r [NUM_CH];
  logic [CH_W-1:0]  rgb5_nxt [NUM_CH];
  logic [SC_W-1:0]  scaled [NUM_CH];
  logic [RES_W-1:0] res [NUM_CH];

  // Handshake: a stage may load when it is empty or its word moves on.
  assign rdy[5]    = !v_r[5] || out_tready;
  assign rdy[4]    = !v_r[4] || rdy[5];
  assign rdy[3]    = !v_r[3] || rdy[4];
  assign rdy[2]    = !v_r[2] || rdy[3];
  assign rdy[1]    = !v_r[1] || rdy[2];
  assign in_tready = rdy[1];
  assign v_nxt     = {v_r[4:1], in_tvalid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int i = 1; i <= 5; i++) begin
        if (rdy[i]) begin
          v_r[i] <= v_nxt[i];
        end
      end
    end
  end

  // Stage 1: limit saturation and lightness, form l * s.
  assign in_hue   = in_tdata[HUE_W-1:0];
  assign in_sat   = in_tdata[HUE_W+SL_W-1:HUE_W];
  assign in_light = in_tdata[HUE_W+2*SL_W-1:HUE_W+SL_W];

  always_comb begin
    h1_nxt  = in_hue;
    s1_nxt  = (in_sat > ONE) ? ONE : in_sat;
    l1_nxt  = (in_light > ONE) ? ONE : in_light;
    ls1_nxt = LS_W'(l1_nxt) * LS_W'(s1_nxt);
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      h1_r  <= h1_nxt;
      s1_r  <= s1_nxt;
      l1_r  <= l1_nxt;
      ls1_r <= ls1_nxt;
    end
  end

  // Stage 2: q and p in Q.F, hue weights of the three channels.
  always_comb begin
    if (l1_r < HALF_ONE) begin
      q2_wide = (Q2_W'(l1_r) << FRAC_BITS) + Q2_W'(ls1_r);
    end else begin
      q2_wide = ((Q2_W'(l1_r) + Q2_W'(s1_r)) << FRAC_BITS) - Q2_W'(ls1_r);
    end
    q2_rnd = q2_wide + Q_RND;
    q_raw  = q2_rnd[Q2_W-1:FRAC_BITS];
    p_diff = ((PQ_W + 1)'(l1_r) << 1) - (PQ_W + 1)'(q_raw);
    p_pos  = p_diff[PQ_W] ? '0 : p_diff[PQ_W-1:0];
    q_fin  = (q_raw < p_pos) ? p_pos : q_raw;
    p2_nxt = p_pos;
    d2_nxt = q_fin - p_pos;

    t_red  = h1_r + THIRD;
    t_blue = h1_r - THIRD;
    k2_nxt[CH_RED]   = hue_weight(t_red);
    k2_nxt[CH_GREEN] = hue_weight(h1_r);
    k2_nxt[CH_BLUE]  = hue_weight(t_blue);
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      p2_r <= p2_nxt;
      d2_r <= d2_nxt;
      k2_r <= k2_nxt;
    end
  end

  // Stage 3: (q - p) * k per channel.
  always_comb begin
    p3_nxt = p2_r;
    for (int c = 0; c < NUM_CH; c++) begin
      prod3_nxt[c] = PR_W'(d2_r) * PR_W'(k2_r[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      p3_r    <= p3_nxt;
      prod3_r <= prod3_nxt;
    end
  end

  // Stage 4: channel value at scale ONE^2.
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      num4_nxt[c] = (NUM_W'(p3_r) << FRAC_BITS) + NUM_W'(prod3_r[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      num4_r <= num4_nxt;
    end
  end

  // Stage 5: times 255 as a shift and subtract, round and clamp.
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      scaled[c]   = (SC_W'(num4_r[c]) << 8) - SC_W'(num4_r[c]) + C_RND;
      res[c]      = scaled[c][SC_W-1:2*FRAC_BITS];
      rgb5_nxt[c] = (res[c] > RES_W'(CH_MAX)) ? CH_MAX : res[c][CH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      rgb5_r <= rgb5_nxt;
    end
  end

  assign out_tvalid = v_r[5];
  assign out_tdata  = {rgb5_r[CH_BLUE], rgb5_r[CH_GREEN], rgb5_r[CH_RED]};

  // Assertions
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> (v_r == '0))
    else $error("pipeline not empty after reset");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (v_r == '1))
    else $error("input stalled while a stage is empty");

  a_stage4_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[4] && !rdy[4]) |=> (v_r[4] && $stable(num4_r[CH_GREEN])))
    else $error("stalled channel sum changed");

  a_p_le_q: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[2] |-> (d2_r <= PQ_W'(ONE)))
    else $error("q - p exceeds one");

endmodule
